### hw/rtl/fnic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnic_pkg
// Format codes, table lookups and shared types for the float to
// normalized integer converter.
// ----------------------------------------------------------------------------
package fnic_pkg;

   localparam int unsigned FmtWidth = 3;
   localparam int unsigned FloatWidth = 32;
   localparam int unsigned NormWidth = 24;
   localparam int unsigned ProdWidth = 56;

   localparam logic [7:0] ExpOne = 8'h7F;
   localparam logic [7:0] ExpMax = 8'hFF;
   localparam logic [9:0] ShiftBase = 10'd170;
   localparam logic [ProdWidth-1:0] RoundHalf = 56'h800;

   typedef enum logic [FmtWidth-1:0] {
      FMT_UN24 = 3'd0,
      FMT_UN16 = 3'd1,
      FMT_UN10 = 3'd2,
      FMT_UN8  = 3'd3,
      FMT_UN2  = 3'd4,
      FMT_SN24 = 3'd5,
      FMT_SN16 = 3'd6,
      FMT_SN8  = 3'd7
   } fmt_type;

   // Format properties for one item.
   typedef struct packed {
      logic                 is_signed;
      logic [4:0]           mag_bits;
      logic [NormWidth-1:0] nmask;
      logic [NormWidth-1:0] maxmag;
   } fmt_info_type;

   // Saturation / special-case result.
   typedef struct packed {
      logic                 hit;
      logic [NormWidth-1:0] value;
   } special_type;

   function automatic fmt_info_type fmt_info(input fmt_type fmt);
      fmt_info_type info;
      info = '0;
      unique case (fmt)
         FMT_UN24: begin info.mag_bits = 5'd24; info.nmask = 24'hFFFFFF; end
         FMT_UN16: begin info.mag_bits = 5'd16; info.nmask = 24'h00FFFF; end
         FMT_UN10: begin info.mag_bits = 5'd10; info.nmask = 24'h0003FF; end
         FMT_UN8:  begin info.mag_bits = 5'd8;  info.nmask = 24'h0000FF; end
         FMT_UN2:  begin info.mag_bits = 5'd2;  info.nmask = 24'h000003; end
         FMT_SN24: begin info.mag_bits = 5'd23; info.nmask = 24'hFFFFFF; end
         FMT_SN16: begin info.mag_bits = 5'd15; info.nmask = 24'h00FFFF; end
         FMT_SN8:  begin info.mag_bits = 5'd7;  info.nmask = 24'h0000FF; end
         default:  begin info.mag_bits = 5'd24; info.nmask = 24'hFFFFFF; end
      endcase
      info.is_signed = (fmt == FMT_SN24) || (fmt == FMT_SN16) || (fmt == FMT_SN8);
      info.maxmag = (24'd1 << info.mag_bits) - 24'd1;
      return info;
   endfunction

endpackage

### hw/rtl/fnic_special.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnic_special
// Detects zeros, denormals, out-of-range values, infinities and NaNs and
// gives their saturated result.
// ----------------------------------------------------------------------------
module fnic_special
   import fnic_pkg::*;
(
   input  fmt_info_type          info,
   input  logic [FloatWidth-1:0] float_bits,
   output special_type           special
);

   logic                 sign;
   logic [7:0]           ex;
   logic                 frac_zero;
   logic [NormWidth-1:0] negmax;

   assign sign = float_bits[31];
   assign ex = float_bits[30:23];
   assign frac_zero = (float_bits[22:0] == 23'd0);
   assign negmax = (24'd0 - info.maxmag) & info.nmask;

   always_comb begin
      special = '0;
      if (!info.is_signed) begin
         if (ex >= ExpOne) begin
            special.hit = 1'b1;
            special.value = (sign && (ex != ExpMax || frac_zero)) ? '0 : info.maxmag;
         end else if (sign || ex == 8'd0) begin
            special.hit = 1'b1;
         end
      end else begin
         if (ex == 8'd0) begin
            special.hit = 1'b1;
         end else if (ex >= ExpOne) begin
            special.hit = 1'b1;
            if (ex == ExpMax) special.value = (frac_zero && sign) ? negmax : info.maxmag;
            else              special.value = sign ? negmax : info.maxmag;
         end
      end
   end

endmodule

### hw/rtl/fnic_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnic_scale
// Scales the significand by (2^M-1), aligns with sticky, rounds half away
// from zero and applies the sign.
// ----------------------------------------------------------------------------
module fnic_scale
   import fnic_pkg::*;
(
   input  fmt_info_type          info,
   input  logic [FloatWidth-1:0] float_bits,
   output logic [NormWidth-1:0]  norm_value
);

   logic [23:0]          sig;
   logic [ProdWidth-1:0] prod;
   logic [9:0]           shift_amt;
   logic                 far;
   logic [5:0]           shift_lo;
   logic [ProdWidth-1:0] lost_mask;
   logic [ProdWidth-1:0] aligned;
   logic [ProdWidth-1:0] rounded;
   logic [NormWidth-1:0] mag;

   assign sig = {1'b1, float_bits[22:0]};
   // sig * (2^32 - 2^(32-M)) as a difference of two shifts
   assign prod = ({32'd0, sig} << 32) - ({32'd0, sig} << (6'd32 - {1'b0, info.mag_bits}));
   assign shift_amt = ShiftBase - {5'd0, info.mag_bits} - {2'd0, float_bits[30:23]};
   assign far = (shift_amt >= 10'd56);
   assign shift_lo = shift_amt[5:0];
   assign lost_mask = (56'd1 << shift_lo) - 56'd1;

   always_comb begin
      if (far) aligned = {55'd0, (prod != '0)};
      else     aligned = (prod >> shift_lo) | {55'd0, ((prod & lost_mask) != '0)};
   end

   assign rounded = aligned + RoundHalf;
   assign mag = rounded[35:12];

   assign norm_value = float_bits[31] ? ((24'd0 - mag) & info.nmask) : (mag & info.nmask);

endmodule

### hw/rtl/float_to_normalized_int_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_normalized_int_core
// Converts single-precision bit patterns to UNORM/SNORM integers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: req_tdata carries the float bit pattern, req_tuser
//   the target format (un24, un16, un10, un8, un2, sn24, sn16, sn8).
//   Result channel rsp_*: rsp_tdata carries the N-bit result, zero-extended
//   to 24 bits (signed formats in two's complement within N bits).
//   Every input item yields exactly one result item, in order.
// Pipeline and throughput:
//   An accepted item passes the input register, then the conversion logic
//   feeding the result register, where rsp_tvalid rises. One item per cycle
//   is sustained while rsp_tready stays high; the rate is set by the
//   single-pass datapath, with no iterative unit.
// Reset:
//   reset (synchronous, active high) empties both stages; nothing else is
//   held since the block is stateless.
// Stall:
//   When rsp_tready is low with a result pending, both stages hold and
//   req_tready drops once the input register is full as well.
// ----------------------------------------------------------------------------
module float_to_normalized_int_core
   import fnic_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [FloatWidth-1:0] req_tdata,   // [31:0] float_bits
   input  logic [FmtWidth-1:0]   req_tuser,   // [2:0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [NormWidth-1:0]  rsp_tdata    // [23:0] norm_value
);

   logic                  in_valid_ff, in_valid_in;
   logic [FloatWidth-1:0] in_bits_ff;
   fmt_type               in_fmt_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NormWidth-1:0]  rsp_data_ff, rsp_data_in;

   logic         advance;
   fmt_info_type info;
   special_type  special;
   logic [NormWidth-1:0] scaled;

   // Move the input stage forward whenever the result register is free or drains.
   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   assign info = fmt_info(in_fmt_ff);

   fnic_special u_special (
      .info       (info),
      .float_bits (in_bits_ff),
      .special    (special)
   );

   fnic_scale u_scale (
      .info       (info),
      .float_bits (in_bits_ff),
      .norm_value (scaled)
   );

   // Special cases override the scaled value.
   assign rsp_data_in = special.hit ? special.value : scaled;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) in_valid_in = req_tvalid;
      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture on handshake, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_bits_ff <= req_tdata;
         in_fmt_ff <= fmt_type'(req_tuser);
      end
      if (advance && in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
